// ===== hdl/i2p_pkg.sv =====
// i2p_pkg: shared types, character constants and helper functions for the
// infix to prefix converter. No dependencies.
`timescale 1ns / 1ps

package i2p_pkg;

	// character codes
	localparam logic [7:0] CHR_LPAREN = 8'h28;
	localparam logic [7:0] CHR_RPAREN = 8'h29;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_CARET  = 8'h5E;
	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_SLASH  = 8'h2F;
	localparam logic [7:0] CHR_PLUS   = 8'h2B;
	localparam logic [7:0] CHR_MINUS  = 8'h2D;
	localparam logic [7:0] CHR_NUL    = 8'h00;

	// operand ranges
	localparam logic [7:0] CHR_DIGIT_LO = 8'h30;
	localparam logic [7:0] CHR_DIGIT_HI = 8'h39;
	localparam logic [7:0] CHR_UPPER_LO = 8'h41;
	localparam logic [7:0] CHR_UPPER_HI = 8'h5A;
	localparam logic [7:0] CHR_LOWER_LO = 8'h61;
	localparam logic [7:0] CHR_LOWER_HI = 8'h7A;

	// class of a scanned character
	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_RPAREN,
		CLS_LPAREN,
		CLS_OPERAND,
		CLS_OPERATOR
	} cls_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // input transaction accepted
		logic scan_rd;    // read input store at count-1, decrement count
		logic push;       // push current character
		logic emit_cur;   // append current character to output store
		logic top_rd;     // read stack top
		logic pop_emit;   // pop stack top into output store
		logic drop_top;   // pop stack top and discard it
		logic out_rd;     // read output store at count-1, decrement count
		logic out_load;   // load result register from output store
		logic out_empty;  // load result register with the empty result
		logic clear;      // clear parenthesis and overflow flags
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic sp_zero;
		logic oc_zero;
		cls_t cur_cls;
		logic top_rparen;
		logic pop_ok;
		logic out_free;
	} status_t;

	// operator precedence
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CHR_PLUS, CHR_MINUS: p = 2'd1;
			CHR_STAR, CHR_SLASH: p = 2'd2;
			CHR_CARET:           p = 2'd3;
			default:             p = 2'd0;
		endcase
		return p;
	endfunction

	// character classification
	function automatic cls_t classify(input logic [7:0] c);
		cls_t k;
		if (c == CHR_SPACE)
			k = CLS_SPACE;
		else if (c == CHR_RPAREN)
			k = CLS_RPAREN;
		else if (c == CHR_LPAREN)
			k = CLS_LPAREN;
		else if ((c >= CHR_DIGIT_LO && c <= CHR_DIGIT_HI) ||
				(c >= CHR_UPPER_LO && c <= CHR_UPPER_HI) ||
				(c >= CHR_LOWER_LO && c <= CHR_LOWER_HI))
			k = CLS_OPERAND;
		else
			k = CLS_OPERATOR;
		return k;
	endfunction

endpackage

// ===== hdl/i2p_ram.sv =====
// i2p_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module i2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/i2p_datapath.sv =====
// i2p_datapath: input store, operator stack, output store, counters, flags
// and the result register. Depends on i2p_pkg and i2p_ram.
`timescale 1ns / 1ps

module i2p_datapath import i2p_pkg::*; #(
	parameter int MAX_CHARS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    st,
	input  logic [7:0] sym,
	input  logic       out_ready,
	output logic       out_tvalid,
	output logic [7:0] out_symbol,
	output logic       out_valid,
	output logic       out_last,
	output logic       balanced,
	output logic       truncated
);

	localparam int AW = $clog2(MAX_CHARS);
	localparam int CW = $clog2(MAX_CHARS + 1);

	logic [CW-1:0] cnt_q, sp_q, oc_q, nest_q;
	logic          unbal_q, ovf_q;
	logic [CW-1:0] cnt_dec, sp_dec, oc_dec;
	logic          room;
	logic [7:0]    cur_c, top_c, out_rdata, out_wdata;
	logic [1:0]    cur_p, top_p;

	// result register
	logic       res_vld_q;
	logic [7:0] res_sym_q;
	logic       res_flag_q, res_last_q, res_bal_q, res_trn_q;

	assign cnt_dec = cnt_q - 1'b1;
	assign sp_dec  = sp_q - 1'b1;
	assign oc_dec  = oc_q - 1'b1;
	assign room    = (cnt_q < CW'(MAX_CHARS));

	// stores
	i2p_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_in_ram (
		.clk   (clk),
		.we    (cmd.load && room),
		.waddr (cnt_q[AW-1:0]),
		.wdata (sym),
		.re    (cmd.scan_rd),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (cur_c)
	);

	i2p_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_stk_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (sp_q[AW-1:0]),
		.wdata (cur_c),
		.re    (cmd.top_rd),
		.raddr (sp_dec[AW-1:0]),
		.rdata (top_c)
	);

	assign out_wdata = cmd.emit_cur ? cur_c : top_c;

	i2p_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_out_ram (
		.clk   (clk),
		.we    (cmd.emit_cur || cmd.pop_emit),
		.waddr (oc_q[AW-1:0]),
		.wdata (out_wdata),
		.re    (cmd.out_rd),
		.raddr (oc_dec[AW-1:0]),
		.rdata (out_rdata)
	);

	// precedence compare for an arriving operator against the stack top
	assign cur_p = prec_of(cur_c);
	assign top_p = prec_of(top_c);

	always_comb begin
		st.cnt_zero   = (cnt_q == '0);
		st.sp_zero    = (sp_q == '0);
		st.oc_zero    = (oc_q == '0);
		st.cur_cls    = classify(cur_c);
		st.top_rparen = (top_c == CHR_RPAREN);
		st.pop_ok     = (top_p > cur_p) || ((cur_c == CHR_CARET) && (top_p == cur_p));
		st.out_free   = !res_vld_q || out_ready;
	end

	// counters and parenthesis tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sp_q    <= '0;
			oc_q    <= '0;
			nest_q  <= '0;
			unbal_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			// input count
			if (cmd.load && room)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.scan_rd)
				cnt_q <= cnt_dec;

			// stack pointer
			if (cmd.push)
				sp_q <= sp_q + 1'b1;
			else if (cmd.pop_emit || cmd.drop_top)
				sp_q <= sp_dec;

			// output count
			if (cmd.emit_cur || cmd.pop_emit)
				oc_q <= oc_q + 1'b1;
			else if (cmd.out_rd)
				oc_q <= oc_dec;

			// flags
			if (cmd.clear) begin
				nest_q  <= '0;
				unbal_q <= 1'b0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (!room) begin
					ovf_q <= 1'b1;
				end else if (sym == CHR_LPAREN) begin
					nest_q <= nest_q + 1'b1;
				end else if (sym == CHR_RPAREN) begin
					if (nest_q == '0)
						unbal_q <= 1'b1;
					else
						nest_q <= nest_q - 1'b1;
				end
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.out_load || cmd.out_empty) begin
			res_vld_q <= 1'b1;
		end else if (out_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load || cmd.out_empty) begin
			res_sym_q  <= cmd.out_load ? out_rdata : CHR_NUL;
			res_flag_q <= cmd.out_load;
			res_last_q <= cmd.out_empty || (oc_q == '0);
			res_bal_q  <= !unbal_q && (nest_q == '0);
			res_trn_q  <= ovf_q;
		end
	end

	assign out_tvalid = res_vld_q;
	assign out_symbol = res_sym_q;
	assign out_valid  = res_flag_q;
	assign out_last   = res_last_q;
	assign balanced   = res_bal_q;
	assign truncated  = res_trn_q;

endmodule

// ===== hdl/i2p_ctrl.sv =====
// i2p_ctrl: controller state machine that sequences loading, the right to
// left scan with the operator stack, and the result emission. Depends on i2p_pkg.
`timescale 1ns / 1ps

module i2p_ctrl import i2p_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_SCAN_RD,
		S_SCAN_EX,
		S_TOP_RD,
		S_TOP_EX,
		S_OUT_EMPTY,
		S_OUT_RD,
		S_OUT_LD
	} state_t;

	typedef enum logic [1:0] {
		M_OPER,
		M_PAREN,
		M_DRAIN
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   accept;

	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load = accept;
				if (accept && in_last)
					state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (st.cnt_zero) begin
					mode_d  = M_DRAIN;
					state_d = S_TOP_RD;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_EX;
				end
			end
			S_SCAN_EX: begin
				case (st.cur_cls)
					CLS_SPACE: begin
						state_d = S_SCAN_RD;
					end
					CLS_RPAREN: begin
						cmd.push = 1'b1;
						state_d  = S_SCAN_RD;
					end
					CLS_OPERAND: begin
						cmd.emit_cur = 1'b1;
						state_d      = S_SCAN_RD;
					end
					CLS_LPAREN: begin
						mode_d  = M_PAREN;
						state_d = S_TOP_RD;
					end
					default: begin
						mode_d  = M_OPER;
						state_d = S_TOP_RD;
					end
				endcase
			end
			S_TOP_RD: begin
				if (st.sp_zero) begin
					case (mode_q)
						M_OPER: begin
							cmd.push = 1'b1;
							state_d  = S_SCAN_RD;
						end
						M_PAREN: begin
							state_d = S_SCAN_RD;
						end
						default: begin
							state_d = st.oc_zero ? S_OUT_EMPTY : S_OUT_RD;
						end
					endcase
				end else begin
					cmd.top_rd = 1'b1;
					state_d    = S_TOP_EX;
				end
			end
			S_TOP_EX: begin
				case (mode_q)
					M_PAREN: begin
						if (st.top_rparen) begin
							cmd.drop_top = 1'b1;
							state_d      = S_SCAN_RD;
						end else begin
							cmd.pop_emit = 1'b1;
							state_d      = S_TOP_RD;
						end
					end
					M_OPER: begin
						if (st.pop_ok) begin
							cmd.pop_emit = 1'b1;
							state_d      = S_TOP_RD;
						end else begin
							cmd.push = 1'b1;
							state_d  = S_SCAN_RD;
						end
					end
					default: begin
						cmd.pop_emit = 1'b1;
						state_d      = S_TOP_RD;
					end
				endcase
			end
			S_OUT_EMPTY: begin
				if (st.out_free) begin
					cmd.out_empty = 1'b1;
					cmd.clear     = 1'b1;
					state_d       = S_LOAD;
				end
			end
			S_OUT_RD: begin
				if (st.out_free) begin
					cmd.out_rd = 1'b1;
					state_d    = S_OUT_LD;
				end
			end
			S_OUT_LD: begin
				cmd.out_load = 1'b1;
				if (st.oc_zero) begin
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end else begin
					state_d = S_OUT_RD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			mode_q  <= M_OPER;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

endmodule

// ===== hdl/infix_to_prefix_converter_top.sv =====
// Infix to prefix converter, top level. Depends on i2p_pkg, i2p_ctrl, i2p_datapath.
// Characters are written to the input store as they are accepted; the scan then reads each stored
//   character back (registered store reads), pops the stack through S_TOP_RD and S_TOP_EX, and
//   each result passes S_OUT_RD and S_OUT_LD into the result register, an empty one S_OUT_EMPTY.
// Results wait while the sink is not ready; input resumes only after the last result is loaded.
// Reset: arst_n clears the controller, counters, flags and result valid; stores are not cleared.
`timescale 1ns / 1ps

module infix_to_prefix_converter_top import i2p_pkg::*; #(
	parameter int MAX_CHARS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // last_symbol
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_symbol
	output logic       m_tlast,   // out_last
	output logic [2:0] m_tuser    // [0] out_valid, [1] balanced, [2] truncated
);

	cmd_t    cmd;
	status_t st;
	logic    flag_valid, flag_bal, flag_trn;

	// controller
	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	i2p_datapath #(.MAX_CHARS(MAX_CHARS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.sym        (s_tdata),
		.out_ready  (m_tready),
		.out_tvalid (m_tvalid),
		.out_symbol (m_tdata),
		.out_valid  (flag_valid),
		.out_last   (m_tlast),
		.balanced   (flag_bal),
		.truncated  (flag_trn)
	);

	assign m_tuser = {flag_trn, flag_bal, flag_valid};

endmodule
